[src/hppm_pkg.sv]
package hppm_pkg;

  // Default sizes of the pattern store and of the height window.
  localparam int unsigned PatternDepth = 256;
  localparam int unsigned MapSide = 128;
  // Offsets are saturated to plus or minus this reach when a point is loaded.
  localparam int unsigned OffsetReach = 32;

  localparam int unsigned NumOrient = 8;
  localparam int unsigned OffW = 7;
  localparam int unsigned HgtW = 10;
  localparam int unsigned PatW = 2 * OffW + HgtW;
  // Width of the signed height difference after levelling.
  localparam int unsigned DiffW = HgtW + 3;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WRITE = 2'd2,
    OP_TEST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_OOW   = 2'd2
  } status_e;

  localparam logic [2:0] LastOrient = 3'(NumOrient - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic       rd_first;
    logic       start;
    logic       emit;
    logic       emit_short;
    logic       emit_last;
    logic [2:0] orient;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic signed [OffW:0] ox;
    logic signed [OffW:0] oz;
  } xy_t;

  // Rotations and reflections of a pattern offset.
  function automatic xy_t orient_xy(logic [2:0] t, logic signed [OffW-1:0] dx,
                                    logic signed [OffW-1:0] dz);
    xy_t r;
    logic signed [OffW:0] x;
    logic signed [OffW:0] z;
    x = (OffW + 1)'(dx);
    z = (OffW + 1)'(dz);
    unique case (t)
      3'd0: begin r.ox = x;  r.oz = z;  end
      3'd1: begin r.ox = -z; r.oz = x;  end
      3'd2: begin r.ox = -x; r.oz = -z; end
      3'd3: begin r.ox = z;  r.oz = -x; end
      3'd4: begin r.ox = -x; r.oz = z;  end
      3'd5: begin r.ox = x;  r.oz = -z; end
      3'd6: begin r.ox = z;  r.oz = x;  end
      default: begin r.ox = -z; r.oz = -x; end
    endcase
    return r;
  endfunction

  // Saturates a loaded offset to the configured reach.
  function automatic logic signed [OffW-1:0] clamp_reach(logic signed [OffW-1:0] v);
    logic signed [HgtW-1:0] w;
    logic signed [HgtW-1:0] lim;
    logic signed [HgtW-1:0] r;
    w = HgtW'(v);
    lim = HgtW'(OffsetReach);
    if (w > lim) begin
      r = lim;
    end else if (w < -lim) begin
      r = -lim;
    end else begin
      r = w;
    end
    return r[OffW-1:0];
  endfunction

endpackage

[src/hppm_ram.sv]
module hppm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/hppm_ctrl.sv]
module hppm_ctrl #(
  parameter int unsigned PATTERN_DEPTH = hppm_pkg::PatternDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           op_i,
  input  logic [3:0]                           orient_select_i,
  input  logic [$clog2(PATTERN_DEPTH+1)-1:0]   count_i,
  input  hppm_pkg::sts_t                       sts_i,
  output hppm_pkg::cmd_t                       cmd_o,
  output logic [$clog2(PATTERN_DEPTH)-1:0]     rd_addr_o
);

  localparam int unsigned AW = $clog2(PATTERN_DEPTH);
  localparam int unsigned CNW = $clog2(PATTERN_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT,
    S_SHORT
  } state_e;

  state_e state_q;
  logic [AW-1:0] p_q;
  logic [2:0] orient_q;
  logic [2:0] last_q;
  logic drain_q;

  logic take;
  logic is_test;
  logic short_pat;
  logic last_pt;
  logic sel_all;

  assign take = in_valid_i && in_ready_o;
  assign is_test = (op_i == hppm_pkg::OP_TEST);
  assign short_pat = (count_i < CNW'(2));
  assign last_pt = ({1'b0, p_q} == (count_i - CNW'(1)));
  assign sel_all = orient_select_i[3];
  assign in_ready_o = (state_q == S_IDLE);
  assign rd_addr_o = p_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.take = take;
    cmd_o.orient = orient_q;
    cmd_o.emit_last = (orient_q == last_q);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.start = take && is_test && !short_pat;
      end
      S_RUN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_first = (p_q == '0);
      end
      S_DRAIN: begin
      end
      S_EMIT: begin
        cmd_o.emit = !sts_i.out_busy;
        cmd_o.start = !sts_i.out_busy && (orient_q != last_q);
      end
      S_SHORT: begin
        cmd_o.emit_short = !sts_i.out_busy;
        cmd_o.emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_q <= '0;
      orient_q <= '0;
      last_q <= '0;
      drain_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (take && is_test) begin
            p_q <= '0;
            orient_q <= sel_all ? 3'd0 : orient_select_i[2:0];
            last_q <= sel_all ? hppm_pkg::LastOrient : orient_select_i[2:0];
            state_q <= short_pat ? S_SHORT : S_RUN;
          end
        end
        S_RUN: begin
          p_q <= p_q + AW'(1);
          if (last_pt) begin
            drain_q <= 1'b1;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_q <= 1'b0;
          if (!drain_q) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!sts_i.out_busy) begin
            if (orient_q == last_q) begin
              state_q <= S_IDLE;
            end else begin
              orient_q <= orient_q + 3'd1;
              p_q <= '0;
              state_q <= S_RUN;
            end
          end
        end
        S_SHORT: begin
          if (!sts_i.out_busy) begin
            orient_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/hppm_dp.sv]
module hppm_dp #(
  parameter int unsigned PATTERN_DEPTH = hppm_pkg::PatternDepth,
  parameter int unsigned MAP_SIDE = hppm_pkg::MapSide
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hppm_pkg::cmd_t                     cmd_i,
  input  logic [$clog2(PATTERN_DEPTH)-1:0]   rd_addr_i,
  output hppm_pkg::sts_t                     sts_o,
  output logic [$clog2(PATTERN_DEPTH+1)-1:0] count_o,
  input  logic                               absolute_mode_i,
  input  logic [7:0]                         tolerance_i,
  input  logic [1:0]                         op_i,
  input  logic [6:0]                         off_x_i,
  input  logic [6:0]                         off_z_i,
  input  logic [9:0]                         pat_height_i,
  input  logic [6:0]                         map_col_i,
  input  logic [6:0]                         map_row_i,
  input  logic [9:0]                         map_height_i,
  input  logic [6:0]                         cand_col_i,
  input  logic [6:0]                         cand_row_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         orientation_o,
  output logic                               matched_o,
  output logic [9:0]                         anchor_height_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);

  localparam int unsigned AW = $clog2(PATTERN_DEPTH);
  localparam int unsigned CNW = $clog2(PATTERN_DEPTH + 1);
  localparam int unsigned XW = $clog2(MAP_SIDE);
  localparam int unsigned WD = MAP_SIDE * MAP_SIDE;
  localparam int unsigned WAW = $clog2(WD);
  localparam int unsigned CW = (XW + 2 > 9) ? XW + 2 : 9;
  localparam int unsigned OW = hppm_pkg::OffW;
  localparam int unsigned HW = hppm_pkg::HgtW;
  localparam int unsigned DW = hppm_pkg::DiffW;

  logic [CNW-1:0] count_q;
  logic [6:0] cand_col_q;
  logic [6:0] cand_row_q;

  // Item writes.
  logic pat_we;
  logic win_we;
  logic [hppm_pkg::PatW-1:0] pat_wdata;
  logic [hppm_pkg::PatW-1:0] pat_rdata;
  logic [WAW-1:0] win_waddr;
  logic [WAW-1:0] win_raddr;
  logic [HW-1:0] win_rdata;

  assign pat_we = cmd_i.take && (op_i == hppm_pkg::OP_LOAD) && (count_q < CNW'(PATTERN_DEPTH));
  assign win_we = cmd_i.take && (op_i == hppm_pkg::OP_WRITE) &&
                  (32'(map_col_i) < MAP_SIDE) && (32'(map_row_i) < MAP_SIDE);
  assign pat_wdata = {hppm_pkg::clamp_reach(off_x_i), hppm_pkg::clamp_reach(off_z_i),
                      pat_height_i};
  assign win_waddr = WAW'(WAW'(map_row_i) * WAW'(MAP_SIDE)) + WAW'(map_col_i);

  hppm_ram #(.Width(hppm_pkg::PatW), .Depth(PATTERN_DEPTH)) u_pat_ram (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(pat_wdata),
    .raddr_i(rd_addr_i),
    .rdata_o(pat_rdata)
  );

  hppm_ram #(.Width(HW), .Depth(WD)) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(win_waddr),
    .wdata_i(map_height_i),
    .raddr_i(win_raddr),
    .rdata_o(win_rdata)
  );

  // Stage B: the pattern entry is out of its memory; place it in the window.
  logic b_vld_q;
  logic b_first_q;
  hppm_pkg::xy_t xy;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] pz;
  logic b_oow;

  assign xy = hppm_pkg::orient_xy(cmd_i.orient, pat_rdata[hppm_pkg::PatW-1 -: OW],
                                  pat_rdata[HW +: OW]);
  assign px = CW'($signed({1'b0, cand_col_q})) + CW'(xy.ox);
  assign pz = CW'($signed({1'b0, cand_row_q})) + CW'(xy.oz);
  assign b_oow = px[CW-1] || pz[CW-1] ||
                 ($unsigned(px) >= CW'(MAP_SIDE)) || ($unsigned(pz) >= CW'(MAP_SIDE));
  assign win_raddr = WAW'(WAW'(pz[XW-1:0]) * WAW'(MAP_SIDE)) + WAW'(px[XW-1:0]);

  // Stage C: the window cell is out of its memory; compare.
  logic c_vld_q;
  logic c_first_q;
  logic c_oow_q;
  logic [HW-1:0] c_ph_q;
  logic [HW-1:0] cell0_q;
  logic [HW-1:0] ph0_q;
  logic oow_q;
  logic mis_q;
  logic [HW-1:0] cell0;
  logic [HW-1:0] ph0;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] tol_s;
  logic bad;

  assign cell0 = c_first_q ? win_rdata : cell0_q;
  assign ph0 = c_first_q ? c_ph_q : ph0_q;
  assign tol_s = $signed(DW'(tolerance_i));

  always_comb begin
    if (absolute_mode_i) begin
      diff = DW'($signed(win_rdata)) - DW'($signed(c_ph_q));
    end else begin
      diff = (DW'($signed(win_rdata)) - DW'($signed(cell0))) -
             (DW'($signed(c_ph_q)) - DW'($signed(ph0)));
    end
  end

  assign bad = (diff > tol_s) || (diff < -tol_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (op_i == hppm_pkg::OP_TEST)) begin
      cand_col_q <= cand_col_i;
      cand_row_q <= cand_row_i;
    end
    b_first_q <= cmd_i.rd_first;
    c_first_q <= b_first_q;
    c_oow_q <= b_oow;
    c_ph_q <= pat_rdata[HW-1:0];
    if (c_vld_q && c_first_q) begin
      cell0_q <= win_rdata;
      ph0_q <= c_ph_q;
    end
  end

  // Output register.
  logic out_valid_q;
  logic [2:0] orient_q;
  logic matched_q;
  logic [HW-1:0] anchor_q;
  hppm_pkg::status_e status_q;
  logic last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      oow_q <= 1'b0;
      mis_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take && (op_i == hppm_pkg::OP_CLEAR)) begin
        count_q <= '0;
      end else if (pat_we) begin
        count_q <= count_q + CNW'(1);
      end
      b_vld_q <= cmd_i.rd_en;
      c_vld_q <= b_vld_q;
      if (cmd_i.start) begin
        oow_q <= 1'b0;
        mis_q <= 1'b0;
      end else if (c_vld_q) begin
        if (c_oow_q) begin
          oow_q <= 1'b1;
        end
        if (bad) begin
          mis_q <= 1'b1;
        end
      end
      if (cmd_i.emit || cmd_i.emit_short) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_short) begin
      orient_q <= '0;
      matched_q <= 1'b0;
      anchor_q <= '0;
      status_q <= hppm_pkg::ST_SHORT;
      last_q <= 1'b1;
    end else if (cmd_i.emit) begin
      orient_q <= cmd_i.orient;
      matched_q <= !oow_q && !mis_q;
      anchor_q <= oow_q ? '0 : cell0_q;
      status_q <= oow_q ? hppm_pkg::ST_OOW : hppm_pkg::ST_OK;
      last_q <= cmd_i.emit_last;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign count_o = count_q;
  assign out_valid_o = out_valid_q;
  assign orientation_o = orient_q;
  assign matched_o = matched_q;
  assign anchor_height_o = anchor_q;
  assign status_o = status_q;
  assign last_o = last_q;

endmodule

[src/heightmap_point_pattern_matcher.sv]
// Sparse height-pattern matcher. Each input item clears the pattern, appends
// a pattern point (offsets saturated to the reach), writes one height sample
// of the square window, or tests a candidate centre. A test gives one result
// item per orientation tested (one, or all eight in order), the final one
// flagged by last; a pattern of fewer than two points gives a single
// too-short result. A test walks the pattern points through a three-stage
// pipeline (pattern memory read, window memory read, compare), one point per
// cycle; the single read port of the window memory sets this rate. After the
// last point of an orientation the pipeline drains and the result is loaded
// once the output register is free, and a full eight-way test repeats this
// for each orientation. The result sits in an output register, so the block
// takes the next item while the last result of a test still waits to be
// taken.
// Configuration is an APB-style port: absolute_mode at 0x0, tolerance at 0x4,
// orient_select at 0x8; write it only while the block is idle.
module heightmap_point_pattern_matcher #(
  parameter int unsigned PATTERN_DEPTH = hppm_pkg::PatternDepth,
  parameter int unsigned MAP_SIDE = hppm_pkg::MapSide
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [6:0]  off_x_i,
  input  logic [6:0]  off_z_i,
  input  logic [9:0]  pat_height_i,
  input  logic [6:0]  map_col_i,
  input  logic [6:0]  map_row_i,
  input  logic [9:0]  map_height_i,
  input  logic [6:0]  cand_col_i,
  input  logic [6:0]  cand_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  orientation_o,
  output logic        matched_o,
  output logic [9:0]  anchor_height_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int unsigned AW = $clog2(PATTERN_DEPTH);
  localparam int unsigned CNW = $clog2(PATTERN_DEPTH + 1);

  localparam logic [1:0] RegAbs = 2'd0;
  localparam logic [1:0] RegTol = 2'd1;
  localparam logic [1:0] RegOrient = 2'd2;

  // Configuration registers.
  logic       absolute_mode_q;
  logic [7:0] tolerance_q;
  logic [3:0] orient_select_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      absolute_mode_q <= 1'b0;
      tolerance_q <= 8'd1;
      orient_select_q <= 4'hF;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegAbs: absolute_mode_q <= pwdata[0];
        RegTol: tolerance_q <= pwdata[7:0];
        RegOrient: orient_select_q <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegAbs: prdata = 32'(absolute_mode_q);
      RegTol: prdata = 32'(tolerance_q);
      RegOrient: prdata = 32'(orient_select_q);
      default: prdata = '0;
    endcase
  end

  hppm_pkg::cmd_t cmd;
  hppm_pkg::sts_t sts;
  logic [AW-1:0] rd_addr;
  logic [CNW-1:0] count;

  // The controller sequences orientations and pattern points.
  hppm_ctrl #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .orient_select_i(orient_select_q),
    .count_i        (count),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .rd_addr_o      (rd_addr)
  );

  // The datapath holds both memories, the compare pipeline and the result.
  hppm_dp #(.PATTERN_DEPTH(PATTERN_DEPTH), .MAP_SIDE(MAP_SIDE)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .sts_o          (sts),
    .count_o        (count),
    .absolute_mode_i(absolute_mode_q),
    .tolerance_i    (tolerance_q),
    .op_i           (op_i),
    .off_x_i        (off_x_i),
    .off_z_i        (off_z_i),
    .pat_height_i   (pat_height_i),
    .map_col_i      (map_col_i),
    .map_row_i      (map_row_i),
    .map_height_i   (map_height_i),
    .cand_col_i     (cand_col_i),
    .cand_row_i     (cand_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .orientation_o  (orientation_o),
    .matched_o      (matched_o),
    .anchor_height_o(anchor_height_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // An orientation with a point outside the window never matches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == hppm_pkg::ST_OOW) |-> !matched_o && (anchor_height_o == '0))
    else $error("out-of-window result carries a match or an anchor");

  // A too-short result is the single, final result of its test.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == hppm_pkg::ST_SHORT) |-> last_o && (orientation_o == '0))
    else $error("too-short result is not a lone final result");

  // A new result is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_short) |-> !(out_valid_o && !out_ready_i))
    else $error("result overwritten before it was taken");

endmodule
